// ===== rtl/core/lru_kv_pkg.sv =====
// ----------------------------------------------------------------------------
// lru_kv_pkg
// Shared types and constants of the LRU key-value cache.
// ----------------------------------------------------------------------------
package lru_kv_pkg;

    // field widths of one transfer
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CFG_W = 5;

    // operation codes carried in the input tuser
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    // read value returned by a get that misses
    localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

    // capacity register value after reset
    localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;

    // one result of an access
    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
    } t_result;

endpackage

// ===== rtl/core/lru_kv_match.sv =====
// ----------------------------------------------------------------------------
// lru_kv_match
// Parallel key compare over all entries and search for the least recent one.
// ----------------------------------------------------------------------------
module lru_kv_match #(
    parameter int N      = 16,
    parameter int RANK_W = 4
) (
    input  logic [N-1:0]                  i_valid,
    input  logic [lru_kv_pkg::KEY_W-1:0]  i_keys [N],
    input  logic [RANK_W-1:0]             i_ranks [N],
    input  logic [lru_kv_pkg::KEY_W-1:0]  i_key,
    input  logic [RANK_W-1:0]             i_victim_rank,
    output logic [N-1:0]                  o_hit_oh,
    output logic [N-1:0]                  o_victim_oh
);
    import lru_kv_pkg::*;

    // keys are unique among valid entries, so at most one bit is set
    always_comb begin
        for (int i = 0; i < N; i++) begin
            o_hit_oh[i]    = i_valid[i] && (i_keys[i] == i_key);
            o_victim_oh[i] = i_valid[i] && (i_ranks[i] == i_victim_rank);
        end
    end

endmodule

// ===== rtl/core/lru_kv_store.sv =====
// ----------------------------------------------------------------------------
// lru_kv_store
// Entry storage with recency ranks; performs one access per enabled cycle.
// ----------------------------------------------------------------------------
module lru_kv_store #(
    parameter int N = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_op_valid,
    input  logic                          i_kind,
    input  logic [lru_kv_pkg::KEY_W-1:0]  i_key,
    input  logic [lru_kv_pkg::VAL_W-1:0]  i_wval,
    input  logic [lru_kv_pkg::CFG_W-1:0]  i_capacity,
    output lru_kv_pkg::t_result           o_result
);
    import lru_kv_pkg::*;

    localparam int RANK_W = (N > 1) ? $clog2(N) : 1;
    localparam int CNT_W  = $clog2(N + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // entry state
    logic [KEY_W-1:0]  r_keys   [N];
    logic [VAL_W-1:0]  r_values [N];
    logic [RANK_W-1:0] r_ranks  [N];
    logic [N-1:0]      r_valid;
    logic [CNT_W-1:0]  r_count;

    logic [N-1:0]      hit_oh;
    logic [N-1:0]      victim_oh;
    logic [RANK_W-1:0] victim_rank;
    logic              hit;
    logic [VAL_W-1:0]  hit_value;
    logic [RANK_W-1:0] hit_rank;
    logic [CMP_W-1:0]  eff_cap;
    logic              full;
    logic              do_evict;
    logic [N-1:0]      kept_valid;
    logic [N-1:0]      free_vec;
    logic [N-1:0]      slot_oh;
    logic              have_slot;
    logic              do_insert;
    logic              do_promote;

    // least recent valid entry holds rank count-1
    assign victim_rank = RANK_W'(r_count - 1'b1);

    lru_kv_match #(
        .N      (N),
        .RANK_W (RANK_W)
    ) u_match (
        .i_valid       (r_valid),
        .i_keys        (r_keys),
        .i_ranks       (r_ranks),
        .i_key         (i_key),
        .i_victim_rank (victim_rank),
        .o_hit_oh      (hit_oh),
        .o_victim_oh   (victim_oh)
    );

    // value and rank of the matching entry
    always_comb begin
        hit_value = '0;
        hit_rank  = '0;
        for (int i = 0; i < N; i++) begin
            if (hit_oh[i]) begin
                hit_value = hit_value | r_values[i];
                hit_rank  = hit_rank | r_ranks[i];
            end
        end
    end

    assign hit = |hit_oh;

    // capacity clamped to the range 1..N
    always_comb begin
        if (i_capacity == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(i_capacity) > CMP_W'(N)) begin
            eff_cap = CMP_W'(N);
        end else begin
            eff_cap = CMP_W'(i_capacity);
        end
    end

    // put of a new key: evict when full, then take the lowest free slot
    assign full       = (CMP_W'(r_count) >= eff_cap) && (r_count != '0);
    assign do_evict   = (i_kind == KIND_PUT) && !hit && full && (|victim_oh);
    assign kept_valid = do_evict ? (r_valid & ~victim_oh) : r_valid;
    assign free_vec   = ~kept_valid;
    assign slot_oh    = free_vec & (~free_vec + 1'b1);
    assign have_slot  = |free_vec;
    assign do_insert  = (i_kind == KIND_PUT) && !hit && have_slot;
    assign do_promote = hit;

    // result of this access
    always_comb begin
        o_result.found      = hit;
        o_result.evicted    = do_evict;
        o_result.read_value = '0;
        if (i_kind == KIND_GET) begin
            o_result.read_value = hit ? hit_value : MISS_VALUE;
        end
    end

    // control state: valid bits, ranks, occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < N; i++) begin
                r_ranks[i] <= '0;
            end
        end else if (i_op_valid) begin
            if (do_promote) begin
                for (int i = 0; i < N; i++) begin
                    if (hit_oh[i]) begin
                        r_ranks[i] <= '0;
                    end else if (r_valid[i] && (r_ranks[i] < hit_rank)) begin
                        r_ranks[i] <= r_ranks[i] + 1'b1;
                    end
                end
            end else if (do_insert) begin
                for (int i = 0; i < N; i++) begin
                    if (slot_oh[i]) begin
                        r_ranks[i] <= '0;
                    end else if (kept_valid[i]) begin
                        r_ranks[i] <= r_ranks[i] + 1'b1;
                    end
                end
                r_valid <= kept_valid | slot_oh;
                r_count <= r_count - CNT_W'(do_evict) + 1'b1;
            end
        end
    end

    // payload: keys and values
    always_ff @(posedge i_clk) begin
        if (i_op_valid) begin
            for (int i = 0; i < N; i++) begin
                if (do_insert && slot_oh[i]) begin
                    r_keys[i]   <= i_key;
                    r_values[i] <= i_wval;
                end else if ((i_kind == KIND_PUT) && hit_oh[i]) begin
                    r_values[i] <= i_wval;
                end
            end
        end
    end

endmodule

// ===== rtl/core/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): tuser is the operation (0 get, 1 put), tdata
//   carries the key and the value to store. Output stream (m_axis): one
//   transfer per input transfer, in order, with the read value in tdata and
//   the found / evicted flags in tuser.
//   A transfer is captured in an input register, then looked up and applied
//   to the entry table once the output register is free, and the result
//   lands in an output register. One access completes per cycle while the
//   receiver does not stall; the parallel key compare and rank update
//   against all CAPACITY entries are done together in that lookup step.
//   The capacity register limits the entries in use (0 acts as 1, values
//   above CAPACITY act as CAPACITY); write it only while the cache is idle.
//   Reset empties the cache and sets capacity to 16.
//   When the receiver stalls, the result is held in the output register and
//   one more item may wait in the input register; then s_axis_tready drops.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int CAPACITY = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // capacity register write
    input  logic                         i_cfg_we,
    input  logic [lru_kv_pkg::CFG_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [63:0]                  s_axis_tdata,   // key[31:0], write_value[63:32]
    input  logic                         s_axis_tuser,   // kind[0]
    // output stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [31:0]                  m_axis_tdata,   // read_value[31:0]
    output logic [1:0]                   m_axis_tuser    // found[0], evicted[1]
);
    import lru_kv_pkg::*;

    logic [CFG_W-1:0] r_capacity;
    logic             r_in_valid;
    logic             r_in_kind;
    logic [KEY_W-1:0] r_in_key;
    logic [VAL_W-1:0] r_in_wval;
    logic             r_out_valid;
    t_result          r_out;
    t_result          result;
    logic             advance;
    logic             in_take;

    // handshake: the access moves on when the output register is empty or being read
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_kind <= s_axis_tuser;
            r_in_key  <= s_axis_tdata[KEY_W-1:0];
            r_in_wval <= s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
        end
    end

    // entry table and lookup
    lru_kv_store #(
        .N (CAPACITY)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (advance),
        .i_kind     (r_in_kind),
        .i_key      (r_in_key),
        .i_wval     (r_in_wval),
        .i_capacity (r_capacity),
        .o_result   (result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.read_value;
    assign m_axis_tuser  = {r_out.evicted, r_out.found};

    // every accepted transfer is held in the input register next cycle
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted transfer not captured");

    // every access that moves on produces a result next cycle
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result register not loaded");

    // a result without a hit reads either the miss marker or zero
    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.found) |->
            (r_out.read_value == MISS_VALUE || r_out.read_value == '0))
        else $error("unexpected read value on miss");

    // an eviction only happens on a put that did not hit
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.evicted) |-> (!r_out.found && r_out.read_value == '0))
        else $error("eviction on a hit or on a get");

endmodule
